### rtl/dddf_pkg.sv
// Shared constants and control types for the decimal digit display formatter.
`default_nettype none

package dddf_pkg;

    // Display command and character constants
    localparam logic [7:0] SET_ADDR   = 8'h80;
    localparam logic [7:0] ADDR_TIME  = 8'h0F;
    localparam logic [7:0] ADDR_DIST  = 8'h4F;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    localparam int VALUE_W  = 16;
    localparam int DIGITS   = 5;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int NDIG_W   = 3;
    localparam int STEP_W   = 4;

    // Output byte selector
    localparam logic [1:0] SEL_CMD   = 2'd0;
    localparam logic [1:0] SEL_DIGIT = 2'd1;
    localparam logic [1:0] SEL_DOT   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       conv_step;
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_last;
        logic       digit_shift;
    } dddf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic              dist_mode;
        logic [NDIG_W-1:0] ndig;
    } dddf_status_t;

endpackage

`default_nettype wire

### rtl/dddf_datapath.sv
// Datapath: double-dabble converter, digit shifter and output byte register.
`default_nettype none

module dddf_datapath (
    input  wire                          aclk,
    input  wire [dddf_pkg::VALUE_W-1:0]  value,
    input  wire                          opcode,
    input  dddf_pkg::dddf_cmd_t          cmd,
    output dddf_pkg::dddf_status_t       status,
    output logic [7:0]                   lcd_byte,
    output logic                         is_data,
    output logic                         last
);
    import dddf_pkg::*;

    logic [VALUE_W-1:0] bin_reg,  bin_next;
    logic [BCD_W-1:0]   bcd_reg,  bcd_next;
    logic               dist_reg, dist_next;
    logic [7:0]         byte_reg, byte_next;
    logic               data_reg, data_next;
    logic               last_reg, last_next;
    logic [BCD_W-1:0]   bcd_adj;

    // Add-3 correction on every digit of five or more
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Number of significant digits, zero for a zero value
    always_comb begin
        if (bcd_reg[19:16] != 4'd0) begin
            status.ndig = 3'd5;
        end else if (bcd_reg[15:12] != 4'd0) begin
            status.ndig = 3'd4;
        end else if (bcd_reg[11:8] != 4'd0) begin
            status.ndig = 3'd3;
        end else if (bcd_reg[7:4] != 4'd0) begin
            status.ndig = 3'd2;
        end else if (bcd_reg[3:0] != 4'd0) begin
            status.ndig = 3'd1;
        end else begin
            status.ndig = 3'd0;
        end
        status.dist_mode = dist_reg;
    end

    // Conversion and digit shifting
    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        dist_next = dist_reg;
        if (cmd.load_in) begin
            bin_next  = value;
            bcd_next  = '0;
            dist_next = opcode;
        end else if (cmd.conv_step) begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end else if (cmd.digit_shift) begin
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
        end
    end

    // Output byte select
    always_comb begin
        byte_next = byte_reg;
        data_next = data_reg;
        last_next = last_reg;
        if (cmd.out_load) begin
            last_next = cmd.out_last;
            unique case (cmd.out_sel)
                SEL_CMD: begin
                    byte_next = SET_ADDR | (dist_reg ? ADDR_DIST : ADDR_TIME);
                    data_next = 1'b0;
                end
                SEL_DIGIT: begin
                    byte_next = ASCII_ZERO + {4'd0, bcd_reg[3:0]};
                    data_next = 1'b1;
                end
                default: begin
                    byte_next = DOT_CHAR;
                    data_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        dist_reg <= dist_next;
        byte_reg <= byte_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign lcd_byte = byte_reg;
    assign is_data  = data_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

### rtl/dddf_ctrl.sv
// Controller: sequences conversion steps and the byte emission of one item.
`default_nettype none

module dddf_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    input  dddf_pkg::dddf_status_t  status,
    output dddf_pkg::dddf_cmd_t     cmd
);
    import dddf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_CMD  = 3'd2;
    localparam logic [2:0] ST_DIG0 = 3'd3;
    localparam logic [2:0] ST_DOT  = 3'd4;
    localparam logic [2:0] ST_DIGS = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg,   cnt_next;
    logic [NDIG_W-1:0] rem_reg,   rem_next;
    logic              valid_reg, valid_next;
    logic              out_free;

    assign out_free = !valid_reg || m_tready;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_CMD;
                    if (status.dist_mode) begin
                        rem_next   = (status.ndig == 3'd0) ? 3'd0 : status.ndig - 3'd1;
                        state_next = ST_DIG0;
                    end else if (status.ndig == 3'd0) begin
                        // time mode zero: address command alone
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        rem_next   = status.ndig;
                        state_next = ST_DIGS;
                    end
                end
            end
            ST_DIG0: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = SEL_DIGIT;
                    cmd.digit_shift = 1'b1;
                    state_next      = ST_DOT;
                end
            end
            ST_DOT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_DOT;
                    if (rem_reg == 3'd0) begin
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_DIGS;
                    end
                end
            end
            ST_DIGS: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = SEL_DIGIT;
                    cmd.digit_shift = 1'b1;
                    rem_next        = rem_reg - 3'd1;
                    if (rem_reg == 3'd1) begin
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

### rtl/decimal_digit_display_formatter.sv
// Top level: decimal digit display formatter for a cursor-decrement character display.
`default_nettype none

// Each input item (a 16-bit value, with the mode on s_tuser) becomes one run of
// display bytes: a set-address command (0x8F in time mode, 0xCF in distance mode),
// then ASCII digits least significant first; distance mode puts '.' after the
// lowest digit. An item is accepted, passes 16 steps of the shift-and-add-3
// binary-to-decimal loop, and is emitted at one byte per cycle (1 to 7 bytes)
// while the output is not stalled.
// The single output register lets the next item be accepted while the final
// byte of a run still waits to be taken.

module decimal_digit_display_formatter (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] value
    input  wire         s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] lcd_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast
);
    import dddf_pkg::*;

    dddf_cmd_t    cmd;
    dddf_status_t status;

    dddf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dddf_datapath u_datapath (
        .aclk     (aclk),
        .value    (s_tdata),
        .opcode   (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .lcd_byte (m_tdata),
        .is_data  (m_tuser),
        .last     (m_tlast)
    );

    // After an item is taken the block is busy converting
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item in conversion");

    // A command byte ending a run is only the time-mode zero case
    a_cmd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata == (SET_ADDR | ADDR_TIME))
        else $error("command byte ends run outside time-mode zero");

    // Character bytes are decimal digits or the point
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata == DOT_CHAR) ||
            (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_ZERO + 8'd9))
        else $error("character byte is not a digit or point");

endmodule

`default_nettype wire
